// File: hw/rtl/assert_macros.svh
// Assertion macros used by the checker of the automaton block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check that is switched off while reset is asserted.
`define TDFA_CHECK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Clocked check that also holds while reset is asserted.
`define TDFA_CHECK_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

// File: hw/rtl/tdfa_pkg.sv
// Types, constants and codes of the table driven automaton acceptor.
package tdfa_pkg;

    // Field widths of the words on the streams.
    localparam int STATE_W     = 4;
    localparam int SYM_W       = 8;
    localparam int IDX_W       = 5;
    localparam int MASK_W      = 16;
    localparam int CMD_W       = 2;
    localparam int STATUS_W    = 2;
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 8;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 16;

    // States at or above this count are never accepting.
    localparam int NUM_STATES = 16;

    // Default number of table slots.
    localparam int NUM_ENTRIES_DEF = 32;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_START_STATE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACCEPT_MASK = 1'b1;

    typedef enum logic [CMD_W-1:0] {
        CMD_WRITE  = 2'd0,
        CMD_SYMBOL = 2'd1,
        CMD_END    = 2'd2
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_ACCEPT   = 2'd0,
        STAT_NO_MATCH = 2'd1,
        STAT_REJECT   = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        FSM_IDLE,
        FSM_SCAN,
        FSM_REPORT
    } fsm_t;

    // Stored part of one transition entry; the valid flag lives in flip-flops.
    typedef struct packed {
        logic [STATE_W-1:0] from_state;
        logic [STATE_W-1:0] next_state;
        logic [SYM_W-1:0]   sym;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // Request to the shared match unit.
    typedef struct packed {
        entry_t             entry;
        logic               entry_valid;
        logic [STATE_W-1:0] cur_state;
        logic [SYM_W-1:0]   sym;
    } match_req_t;

    // Answer of the shared match unit.
    typedef struct packed {
        logic               hit;
        logic [STATE_W-1:0] next_state;
    } match_rsp_t;

endpackage

// File: hw/rtl/tdfa_ram.sv
// Generic single write port, single read port RAM with registered read data.
module tdfa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: hw/rtl/tdfa_match.sv
// Shared compare unit: checks one table entry against the current state and symbol.
module tdfa_match (
    input  tdfa_pkg::match_req_t req,
    output tdfa_pkg::match_rsp_t rsp
);

    // An entry matches when it is enabled and both keys are equal.
    always_comb
    begin
        rsp.hit        = req.entry_valid
                         && (req.entry.from_state == req.cur_state)
                         && (req.entry.sym == req.sym);
        rsp.next_state = req.entry.next_state;
    end

endmodule

// File: hw/rtl/table_driven_dfa_acceptor.sv
// Table write: written in the cycle it is taken. Symbol: a scan of the table, one slot
// per cycle through one read port and one compare unit, until a slot matches or the
// last slot is compared; a failed sequence skips the scan. End of sequence: the
// result word loads the output register once that register is free after the last
// symbol's work. Reset clears all slot valid flags, the registers and the sequence
// state at once; no clearing pass is needed.
module table_driven_dfa_acceptor #(
    parameter int NUM_ENTRIES = tdfa_pkg::NUM_ENTRIES_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // Input words.
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // [4:0] entry_index, [8:5] entry_from_state, [12:9] entry_next_state,
    // [13] entry_valid, [21:14] symbol_type, [23:22] zero
    input  logic [tdfa_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // [1:0] command
    input  logic [tdfa_pkg::CMD_W-1:0]          s_axis_tuser,
    input  logic                                s_axis_tlast,
    // Result words.
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [1:0] status, [5:2] end_state, [7:6] zero
    output logic [tdfa_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    // Configuration writes.
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [tdfa_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [tdfa_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int AW = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
    localparam logic [AW-1:0] LAST_SLOT = AW'(NUM_ENTRIES - 1);

    // Unpacked input fields.
    tdfa_pkg::cmd_t                    in_cmd;
    logic [tdfa_pkg::IDX_W-1:0]        in_idx;
    logic [tdfa_pkg::STATE_W-1:0]      in_from;
    logic [tdfa_pkg::STATE_W-1:0]      in_next;
    logic                              in_valid_bit;
    logic [tdfa_pkg::SYM_W-1:0]        in_sym;
    logic                              in_accept;

    // Control and sequence registers.
    tdfa_pkg::fsm_t                    fsm_reg, fsm_next;
    logic [tdfa_pkg::STATE_W-1:0]      start_reg, start_next;
    logic [tdfa_pkg::MASK_W-1:0]       mask_reg, mask_next;
    logic [tdfa_pkg::STATE_W-1:0]      cur_reg, cur_next;
    logic                              in_seq_reg, in_seq_next;
    logic                              failed_reg, failed_next;
    logic [tdfa_pkg::SYM_W-1:0]        sym_reg, sym_next;
    logic                              last_reg, last_next;
    logic [NUM_ENTRIES-1:0]            valid_reg, valid_next;
    logic [AW-1:0]                     issue_ptr_reg, issue_ptr_next;
    logic [AW-1:0]                     cmp_ptr_reg, cmp_ptr_next;
    logic                              data_ok_reg, data_ok_next;
    logic                              out_valid_reg, out_valid_next;
    tdfa_pkg::status_t                 out_status_reg, out_status_next;
    logic [tdfa_pkg::STATE_W-1:0]      out_end_reg, out_end_next;

    // Table memory and compare unit signals.
    logic                              ram_we;
    tdfa_pkg::entry_t                  ram_wdata;
    tdfa_pkg::entry_t                  ram_rdata;
    logic [tdfa_pkg::ENTRY_W-1:0]      ram_rdata_bits;
    tdfa_pkg::match_req_t              mreq;
    tdfa_pkg::match_rsp_t              mrsp;

    // Sequence opening values and result status.
    logic [tdfa_pkg::STATE_W-1:0]      open_cur;
    logic                              open_failed;
    logic                              cur_accepting;
    logic                              slot_in_range;

    assign in_cmd       = tdfa_pkg::cmd_t'(s_axis_tuser);
    assign in_idx       = s_axis_tdata[4:0];
    assign in_from      = s_axis_tdata[8:5];
    assign in_next      = s_axis_tdata[12:9];
    assign in_valid_bit = s_axis_tdata[13];
    assign in_sym       = s_axis_tdata[21:14];

    assign s_axis_tready = (fsm_reg == tdfa_pkg::FSM_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign cfg_ready     = 1'b1;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {2'b00, out_end_reg, out_status_reg};

    assign slot_in_range = (32'(in_idx) < NUM_ENTRIES);
    assign open_cur      = in_seq_reg ? cur_reg : start_reg;
    assign open_failed   = in_seq_reg ? failed_reg : 1'b0;
    assign cur_accepting = (32'(cur_reg) < tdfa_pkg::NUM_STATES) && mask_reg[cur_reg];

    // Table write port.
    assign ram_we = in_accept && (in_cmd == tdfa_pkg::CMD_WRITE) && slot_in_range;
    always_comb
    begin
        ram_wdata.from_state = in_from;
        ram_wdata.next_state = in_next;
        ram_wdata.sym        = in_sym;
    end

    tdfa_ram #(
        .WIDTH (tdfa_pkg::ENTRY_W),
        .DEPTH (NUM_ENTRIES)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (AW'(in_idx)),
        .wdata (ram_wdata),
        .raddr (issue_ptr_reg),
        .rdata (ram_rdata_bits)
    );

    assign ram_rdata = tdfa_pkg::entry_t'(ram_rdata_bits);

    // The compare unit sees the slot that was read in the previous cycle.
    always_comb
    begin
        mreq.entry       = ram_rdata;
        mreq.entry_valid = valid_reg[cmp_ptr_reg];
        mreq.cur_state   = cur_reg;
        mreq.sym         = sym_reg;
    end

    tdfa_match u_match (
        .req (mreq),
        .rsp (mrsp)
    );

    // State register and all control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fsm_reg        <= tdfa_pkg::FSM_IDLE;
            start_reg      <= '0;
            mask_reg       <= '0;
            cur_reg        <= '0;
            in_seq_reg     <= 1'b0;
            failed_reg     <= 1'b0;
            sym_reg        <= '0;
            last_reg       <= 1'b0;
            valid_reg      <= '0;
            issue_ptr_reg  <= '0;
            cmp_ptr_reg    <= '0;
            data_ok_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_status_reg <= tdfa_pkg::STAT_ACCEPT;
            out_end_reg    <= '0;
        end
        else
        begin
            fsm_reg        <= fsm_next;
            start_reg      <= start_next;
            mask_reg       <= mask_next;
            cur_reg        <= cur_next;
            in_seq_reg     <= in_seq_next;
            failed_reg     <= failed_next;
            sym_reg        <= sym_next;
            last_reg       <= last_next;
            valid_reg      <= valid_next;
            issue_ptr_reg  <= issue_ptr_next;
            cmp_ptr_reg    <= cmp_ptr_next;
            data_ok_reg    <= data_ok_next;
            out_valid_reg  <= out_valid_next;
            out_status_reg <= out_status_next;
            out_end_reg    <= out_end_next;
        end
    end

    // Sequencer: next state and register updates.
    always_comb
    begin
        fsm_next        = fsm_reg;
        start_next      = start_reg;
        mask_next       = mask_reg;
        cur_next        = cur_reg;
        in_seq_next     = in_seq_reg;
        failed_next     = failed_reg;
        sym_next        = sym_reg;
        last_next       = last_reg;
        valid_next      = valid_reg;
        issue_ptr_next  = issue_ptr_reg;
        cmp_ptr_next    = cmp_ptr_reg;
        data_ok_next    = data_ok_reg;
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_end_next    = out_end_reg;

        // The result word leaves when the sink takes it.
        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        // Configuration writes are taken in any cycle.
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                tdfa_pkg::CFG_START_STATE: start_next = cfg_data[tdfa_pkg::STATE_W-1:0];
                tdfa_pkg::CFG_ACCEPT_MASK: mask_next  = cfg_data[tdfa_pkg::MASK_W-1:0];
                default: ;
            endcase
        end

        case (fsm_reg)
            tdfa_pkg::FSM_IDLE:
            begin
                if (in_accept)
                begin
                    case (in_cmd)
                        tdfa_pkg::CMD_WRITE:
                        begin
                            if (slot_in_range)
                            begin
                                valid_next[AW'(in_idx)] = in_valid_bit;
                            end
                        end
                        tdfa_pkg::CMD_SYMBOL:
                        begin
                            in_seq_next = 1'b1;
                            cur_next    = open_cur;
                            failed_next = open_failed;
                            sym_next    = in_sym;
                            last_next   = s_axis_tlast;
                            if (!open_failed)
                            begin
                                // Start the slot scan at slot zero.
                                issue_ptr_next = '0;
                                data_ok_next   = 1'b0;
                                fsm_next       = tdfa_pkg::FSM_SCAN;
                            end
                            else if (s_axis_tlast)
                            begin
                                fsm_next = tdfa_pkg::FSM_REPORT;
                            end
                        end
                        tdfa_pkg::CMD_END:
                        begin
                            in_seq_next = 1'b1;
                            cur_next    = open_cur;
                            failed_next = open_failed;
                            fsm_next    = tdfa_pkg::FSM_REPORT;
                        end
                        default: ;
                    endcase
                end
            end

            tdfa_pkg::FSM_SCAN:
            begin
                // Issue the next read while comparing the slot read before.
                issue_ptr_next = issue_ptr_reg + AW'(1);
                cmp_ptr_next   = issue_ptr_reg;
                data_ok_next   = 1'b1;
                if (data_ok_reg && (mrsp.hit || (cmp_ptr_reg == LAST_SLOT)))
                begin
                    if (mrsp.hit)
                    begin
                        cur_next = mrsp.next_state;
                    end
                    else
                    begin
                        failed_next = 1'b1;
                    end
                    fsm_next = last_reg ? tdfa_pkg::FSM_REPORT : tdfa_pkg::FSM_IDLE;
                end
            end

            tdfa_pkg::FSM_REPORT:
            begin
                // Load the result word once the output register is free.
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_end_next   = cur_reg;
                    if (failed_reg)
                    begin
                        out_status_next = tdfa_pkg::STAT_NO_MATCH;
                    end
                    else if (cur_accepting)
                    begin
                        out_status_next = tdfa_pkg::STAT_ACCEPT;
                    end
                    else
                    begin
                        out_status_next = tdfa_pkg::STAT_REJECT;
                    end
                    in_seq_next = 1'b0;
                    failed_next = 1'b0;
                    fsm_next    = tdfa_pkg::FSM_IDLE;
                end
            end

            default:
            begin
                fsm_next = tdfa_pkg::FSM_IDLE;
            end
        endcase
    end

endmodule

// File: hw/rtl/tdfa_checker.sv
// Port level checker for the automaton acceptor, bound to its top level.
`include "assert_macros.svh"

module tdfa_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              s_axis_tvalid,
    input logic                              s_axis_tready,
    input logic [tdfa_pkg::CMD_W-1:0]        s_axis_tuser,
    input logic                              m_axis_tvalid,
    input logic                              m_axis_tready,
    input logic [tdfa_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);

    logic in_fire;
    logic in_end;
    logic in_write;
    logic out_stall;
    logic status_ok;

    // Handshake and field decodes used by the checks below.
    assign in_fire   = s_axis_tvalid && s_axis_tready;
    assign in_end    = in_fire && (s_axis_tuser == tdfa_pkg::CMD_END);
    assign in_write  = in_fire && (s_axis_tuser == tdfa_pkg::CMD_WRITE);
    assign out_stall = m_axis_tvalid && !m_axis_tready;
    assign status_ok = m_axis_tdata[1:0] inside {tdfa_pkg::STAT_ACCEPT,
                                                 tdfa_pkg::STAT_NO_MATCH,
                                                 tdfa_pkg::STAT_REJECT};

    // A pending result word is not withdrawn.
    `TDFA_CHECK(a_out_held, out_stall |=> m_axis_tvalid, "result word withdrawn")

    // Reset leaves no result word valid behind it.
    `TDFA_CHECK_ALWAYS(a_out_reset, !rst_n |=> !m_axis_tvalid, "result word valid in reset")

    // An end command always moves the block into reporting.
    `TDFA_CHECK(a_end_busy, in_end |=> !s_axis_tready, "end command did not start a report")

    // A table write finishes in the cycle it is taken.
    `TDFA_CHECK(a_write_quick, in_write |=> s_axis_tready, "table write stalled the input")

    // Only defined status codes appear on a result word.
    `TDFA_CHECK(a_status_code, m_axis_tvalid |-> status_ok, "undefined status code")

endmodule

bind table_driven_dfa_acceptor tdfa_checker u_tdfa_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
